// ===== sv/bra_pkg.sv =====
`timescale 1ns / 1ps
// Shared package for the banker's resource allocator.
// Sizes, codes, datapath command/status structs and FSM types; no dependencies.
package bra_pkg;

  localparam int NUM_RES      = 5;
  localparam int NUM_PROC     = 16;
  localparam int QUEUE_DEPTH  = 8;
  localparam int AMOUNT_WIDTH = 16;

  localparam int FIELD_CNT = 5;
  localparam int FIELD_W   = 16;
  localparam int OPC_W     = 3;
  localparam int PID_W     = 4;
  localparam int STAT_W    = 4;
  localparam int CFG_W     = 5;

  localparam int ROW_W  = $clog2(NUM_PROC);
  localparam int PC_W   = $clog2(NUM_PROC + 1);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QI_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WORK_W = AMOUNT_WIDTH + $clog2(NUM_PROC + 1);

  typedef logic [AMOUNT_WIDTH-1:0] amt_t;
  typedef amt_t [NUM_RES-1:0] amt_vec_t;

  typedef enum logic [OPC_W-1:0] {
    OP_SET_AVAIL  = 3'd0,
    OP_LOAD_MAX   = 3'd1,
    OP_LOAD_ALLOC = 3'd2,
    OP_CHECK      = 3'd3,
    OP_ALLOCATE   = 3'd4,
    OP_RELEASE    = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_UNSAFE_WAIT = 4'd1,
    ST_SHORT_WAIT  = 4'd2,
    ST_INVALID     = 4'd3,
    ST_SAFE        = 4'd4,
    ST_UNSAFE      = 4'd5,
    ST_LOADED      = 4'd6,
    ST_MAX_BELOW   = 4'd7,
    ST_QUEUE_FULL  = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_LOAD,
    DP_SCAN_INIT,
    DP_SCAN_STEP,
    DP_WALK_INIT,
    DP_WALK_STEP,
    DP_APPLY,
    DP_ROLLBACK,
    DP_RELEASE,
    DP_ENQ,
    DP_Q_LOAD,
    DP_Q_ADV,
    DP_Q_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   keep;
    logic   use_i;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic [PID_W-1:0] pid;
    logic [PC_W-1:0]  row;
    logic             load_bad;
    logic             pid_bad;
    logic             need_bad;
    logic             short_avail;
    logic             scan_end;
    logic             row_bad;
    logic             walk_safe;
    logic             rel_bad;
    logic             q_full;
    logic             q_end;
    logic             q_last;
    logic             q_empty;
    logic [QC_W-1:0]  q_cnt;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GRANT,
    S_SCAN,
    S_WALK,
    S_GRANT_DONE,
    S_REL_CHK,
    S_REL_NEXT,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    M_CHECK,
    M_ALLOC,
    M_RECHECK
  } mode_t;

endpackage

// ===== sv/bra_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request, result and config beats.
// Depends on bra_pkg.
interface bra_in_if;
  logic                          valid;
  logic                          ready;
  logic [bra_pkg::OPC_W-1:0]     opcode;
  logic [bra_pkg::PID_W-1:0]     process_id;
  logic [bra_pkg::FIELD_W-1:0]   amount_0;
  logic [bra_pkg::FIELD_W-1:0]   amount_1;
  logic [bra_pkg::FIELD_W-1:0]   amount_2;
  logic [bra_pkg::FIELD_W-1:0]   amount_3;
  logic [bra_pkg::FIELD_W-1:0]   amount_4;
  modport source (output valid, opcode, process_id, amount_0, amount_1, amount_2, amount_3,
                  amount_4, input ready);
  modport sink (input valid, opcode, process_id, amount_0, amount_1, amount_2, amount_3,
                amount_4, output ready);
endinterface

interface bra_out_if;
  logic                        valid;
  logic                        ready;
  logic [bra_pkg::STAT_W-1:0]  status;
  logic [bra_pkg::PID_W-1:0]   subject_id;
  logic                        last;
  modport source (output valid, status, subject_id, last, input ready);
  modport sink (input valid, status, subject_id, last, output ready);
endinterface

interface bra_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bra_pkg::CFG_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/bra_dp.sv =====
`timescale 1ns / 1ps
// Datapath: resource tables, wait queue, safety-walk work vector and counters.
// Executes one command per cycle from bra_ctrl; depends on bra_pkg.
module bra_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bra_pkg::dp_cmd_t            cmd,
  output bra_pkg::dp_stat_t           stat,
  input  logic [bra_pkg::OPC_W-1:0]   in_opcode,
  input  logic [bra_pkg::PID_W-1:0]   in_pid,
  input  bra_pkg::amt_vec_t           in_amt,
  input  logic                        cfg_we,
  input  logic [bra_pkg::CFG_W-1:0]   cfg_data
);
  import bra_pkg::*;

  logic [CFG_W-1:0]  pcfg_r;
  amt_vec_t          avail_r;
  amt_vec_t          max_r [NUM_PROC];
  amt_vec_t          alloc_r [NUM_PROC];
  logic [WORK_W-1:0] work_r [NUM_RES];
  logic [NUM_PROC-1:0] fin_r;
  logic [PC_W-1:0]   done_r;
  logic [PC_W-1:0]   i_r;
  logic [QC_W-1:0]   j_r, w_r, cnt_r;
  logic [PID_W-1:0]  qid_r [QUEUE_DEPTH];
  amt_vec_t          qamt_r [QUEUE_DEPTH];
  logic [OPC_W-1:0]  req_op_r;
  logic [PID_W-1:0]  req_pid_r;
  amt_vec_t          req_amt_r;

  logic [PC_W-1:0]  pc;
  logic [ROW_W-1:0] wrow, rrow;
  amt_vec_t         rmax, ralloc;
  logic             row_bad, fits, need_bad, short_avail, rel_bad;
  logic [QI_W-1:0]  qi, wi, ci;

  always_comb begin
    pc = (32'(pcfg_r) > NUM_PROC) ? PC_W'(NUM_PROC) : PC_W'(pcfg_r);
    wrow = ROW_W'(req_pid_r);
    rrow = cmd.use_i ? i_r[ROW_W-1:0] : wrow;
    rmax = max_r[rrow];
    ralloc = alloc_r[rrow];
    qi = j_r[QI_W-1:0];
    wi = w_r[QI_W-1:0];
    ci = cnt_r[QI_W-1:0];
    row_bad = 1'b0;
    fits = 1'b1;
    need_bad = 1'b0;
    short_avail = 1'b0;
    rel_bad = 1'b0;
    for (int k = 0; k < NUM_RES; k++) begin
      if (rmax[k] < ralloc[k]) row_bad = 1'b1;
      if (WORK_W'(rmax[k] - ralloc[k]) > work_r[k]) fits = 1'b0;
      if ({1'b0, req_amt_r[k]} + {1'b0, ralloc[k]} > {1'b0, rmax[k]}) need_bad = 1'b1;
      if (req_amt_r[k] > avail_r[k]) short_avail = 1'b1;
      if (req_amt_r[k] > ralloc[k]) rel_bad = 1'b1;
      if (((AMOUNT_WIDTH+1)'(avail_r[k]) + (AMOUNT_WIDTH+1)'(req_amt_r[k]))
          >> AMOUNT_WIDTH != '0) rel_bad = 1'b1;
    end
    stat.op = req_op_r;
    stat.pid = req_pid_r;
    stat.row = i_r;
    stat.load_bad = 32'(req_pid_r) >= NUM_PROC;
    stat.pid_bad = 32'(req_pid_r) >= 32'(pc);
    stat.need_bad = need_bad;
    stat.short_avail = short_avail;
    stat.scan_end = i_r >= pc;
    stat.row_bad = row_bad;
    stat.walk_safe = done_r == pc;
    stat.rel_bad = rel_bad;
    stat.q_full = cnt_r == QC_W'(QUEUE_DEPTH);
    stat.q_end = j_r >= cnt_r;
    stat.q_last = (j_r + QC_W'(1)) == cnt_r;
    stat.q_empty = cnt_r == '0;
    stat.q_cnt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcfg_r <= CFG_W'(NUM_PROC);
      avail_r <= '0;
      for (int p = 0; p < NUM_PROC; p++) begin
        max_r[p] <= '0;
        alloc_r[p] <= '0;
      end
      fin_r <= '0;
      done_r <= '0;
      i_r <= '0;
      j_r <= '0;
      w_r <= '0;
      cnt_r <= '0;
      req_op_r <= '0;
      req_pid_r <= '0;
    end else begin
      if (cfg_we) pcfg_r <= cfg_data;
      case (cmd.op)
        DP_LATCH: begin
          req_op_r <= in_opcode;
          req_pid_r <= in_pid;
          req_amt_r <= in_amt;
        end
        DP_LOAD: begin
          case (req_op_r)
            OP_SET_AVAIL:  avail_r <= req_amt_r;
            OP_LOAD_MAX:   max_r[wrow] <= req_amt_r;
            OP_LOAD_ALLOC: alloc_r[wrow] <= req_amt_r;
            default: ;
          endcase
        end
        DP_SCAN_INIT: i_r <= '0;
        DP_SCAN_STEP: i_r <= i_r + PC_W'(1);
        DP_WALK_INIT: begin
          i_r <= '0;
          fin_r <= '0;
          done_r <= '0;
          for (int k = 0; k < NUM_RES; k++) work_r[k] <= WORK_W'(avail_r[k]);
        end
        DP_WALK_STEP: begin
          if (!fin_r[rrow] && fits) begin
            for (int k = 0; k < NUM_RES; k++) work_r[k] <= work_r[k] + WORK_W'(ralloc[k]);
            fin_r[rrow] <= 1'b1;
            done_r <= done_r + PC_W'(1);
            i_r <= '0;
          end else begin
            i_r <= i_r + PC_W'(1);
          end
        end
        DP_APPLY: begin
          for (int k = 0; k < NUM_RES; k++) begin
            avail_r[k] <= avail_r[k] - req_amt_r[k];
            alloc_r[wrow][k] <= alloc_r[wrow][k] + req_amt_r[k];
          end
          i_r <= '0;
        end
        DP_ROLLBACK: begin
          for (int k = 0; k < NUM_RES; k++) begin
            avail_r[k] <= avail_r[k] + req_amt_r[k];
            alloc_r[wrow][k] <= alloc_r[wrow][k] - req_amt_r[k];
          end
        end
        DP_RELEASE: begin
          for (int k = 0; k < NUM_RES; k++) begin
            avail_r[k] <= avail_r[k] + req_amt_r[k];
            alloc_r[wrow][k] <= alloc_r[wrow][k] - req_amt_r[k];
          end
          j_r <= '0;
          w_r <= '0;
        end
        DP_ENQ: begin
          qid_r[ci] <= req_pid_r;
          qamt_r[ci] <= req_amt_r;
          cnt_r <= cnt_r + QC_W'(1);
        end
        DP_Q_LOAD: begin
          req_pid_r <= qid_r[qi];
          req_amt_r <= qamt_r[qi];
        end
        DP_Q_ADV: begin
          if (cmd.keep) begin
            qid_r[wi] <= qid_r[qi];
            qamt_r[wi] <= qamt_r[qi];
            w_r <= w_r + QC_W'(1);
          end
          j_r <= j_r + QC_W'(1);
        end
        DP_Q_DONE: cnt_r <= w_r;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bra_ctrl.sv =====
`timescale 1ns / 1ps
// Controller FSM: sequences loads, safety walks, grants and queue rechecks,
// and holds the result output register. Depends on bra_pkg.
module bra_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bra_pkg::STAT_W-1:0] out_status,
  output logic [bra_pkg::PID_W-1:0]  out_subject,
  output logic                       out_last,
  output bra_pkg::dp_cmd_t           cmd,
  input  bra_pkg::dp_stat_t          stat
);
  import bra_pkg::*;

  ctl_state_t state_r, state_nxt, ret_r, ret_nxt;
  mode_t      mode_r, mode_nxt;
  status_t    st_r, st_nxt, pst_r, pst_nxt;
  logic [PID_W-1:0] psub_r, psub_nxt;
  logic       plast_r, plast_nxt;
  logic       out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PID_W-1:0]  out_subject_r;
  logic       out_last_r;
  logic       out_free;
  status_t    s;

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_subject = out_subject_r;
  assign out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      mode_r <= M_CHECK;
      st_r <= ST_GRANTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      mode_r <= mode_nxt;
      st_r <= st_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pst_r <= pst_nxt;
    psub_r <= psub_nxt;
    plast_r <= plast_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= pst_r;
      out_subject_r <= psub_r;
      out_last_r <= plast_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    mode_nxt = mode_r;
    st_nxt = st_r;
    pst_nxt = pst_r;
    psub_nxt = psub_r;
    plast_nxt = plast_r;
    cmd = '{op: DP_NOP, keep: 1'b0, use_i: 1'b0};
    in_ready = 1'b0;
    s = st_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pst_nxt = ST_INVALID;
        psub_nxt = stat.pid;
        plast_nxt = 1'b1;
        ret_nxt = S_IDLE;
        case (stat.op)
          OP_SET_AVAIL, OP_LOAD_MAX, OP_LOAD_ALLOC: begin
            state_nxt = S_EMIT;
            if (stat.op == OP_SET_AVAIL || !stat.load_bad) begin
              cmd.op = DP_LOAD;
              pst_nxt = ST_LOADED;
            end
          end
          OP_CHECK: begin
            mode_nxt = M_CHECK;
            cmd.op = DP_SCAN_INIT;
            state_nxt = S_SCAN;
          end
          OP_ALLOCATE: begin
            mode_nxt = M_ALLOC;
            state_nxt = S_GRANT;
          end
          OP_RELEASE: state_nxt = S_REL_CHK;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_GRANT: begin
        if (stat.pid_bad || stat.need_bad) begin
          st_nxt = ST_INVALID;
          state_nxt = S_GRANT_DONE;
        end else if (stat.short_avail) begin
          st_nxt = ST_SHORT_WAIT;
          state_nxt = S_GRANT_DONE;
        end else begin
          cmd.op = DP_APPLY;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.use_i = 1'b1;
        if (stat.scan_end) begin
          cmd.op = DP_WALK_INIT;
          state_nxt = S_WALK;
        end else if (stat.row_bad) begin
          if (mode_r == M_CHECK) begin
            pst_nxt = ST_MAX_BELOW;
            psub_nxt = PID_W'(stat.row);
            plast_nxt = 1'b1;
            ret_nxt = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            cmd.op = DP_ROLLBACK;
            st_nxt = ST_MAX_BELOW;
            state_nxt = S_GRANT_DONE;
          end
        end else begin
          cmd.op = DP_SCAN_STEP;
        end
      end
      S_WALK: begin
        cmd.use_i = 1'b1;
        if (stat.scan_end) begin
          if (mode_r == M_CHECK) begin
            pst_nxt = stat.walk_safe ? ST_SAFE : ST_UNSAFE;
            psub_nxt = '0;
            plast_nxt = 1'b1;
            ret_nxt = S_IDLE;
            state_nxt = S_EMIT;
          end else if (stat.walk_safe) begin
            st_nxt = ST_GRANTED;
            state_nxt = S_GRANT_DONE;
          end else begin
            cmd.op = DP_ROLLBACK;
            st_nxt = ST_UNSAFE_WAIT;
            state_nxt = S_GRANT_DONE;
          end
        end else begin
          cmd.op = DP_WALK_STEP;
        end
      end
      S_GRANT_DONE: begin
        psub_nxt = stat.pid;
        state_nxt = S_EMIT;
        if (mode_r == M_ALLOC) begin
          if (st_r == ST_UNSAFE_WAIT || st_r == ST_SHORT_WAIT) begin
            if (stat.q_full) s = ST_QUEUE_FULL;
            else cmd.op = DP_ENQ;
          end
          pst_nxt = s;
          plast_nxt = 1'b1;
          ret_nxt = S_IDLE;
        end else begin
          cmd.op = DP_Q_ADV;
          cmd.keep = !(st_r == ST_GRANTED || st_r == ST_INVALID);
          pst_nxt = st_r;
          plast_nxt = stat.q_last;
          ret_nxt = S_REL_NEXT;
        end
      end
      S_REL_CHK: begin
        psub_nxt = stat.pid;
        state_nxt = S_EMIT;
        if (stat.pid_bad || stat.rel_bad) begin
          pst_nxt = ST_INVALID;
          plast_nxt = 1'b1;
          ret_nxt = S_IDLE;
        end else begin
          cmd.op = DP_RELEASE;
          pst_nxt = ST_GRANTED;
          plast_nxt = stat.q_empty;
          ret_nxt = S_REL_NEXT;
        end
      end
      S_REL_NEXT: begin
        mode_nxt = M_RECHECK;
        if (stat.q_end) begin
          cmd.op = DP_Q_DONE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_Q_LOAD;
          state_nxt = S_GRANT;
        end
      end
      S_EMIT: begin
        if (out_free) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/bankers_resource_allocator.sv =====
`timescale 1ns / 1ps
// Banker's-algorithm allocator over five resource kinds and sixteen processes.
// Top level: joins bra_ctrl and bra_dp to the channels; depends on bra_pkg, bra_if.
//
// One request beat at a time. The row check visits one process row per cycle;
// the safety walk after it also visits one row per cycle and restarts at row
// 0 after every process it finishes. A release reruns the allocate check for
// each queued request (up to eight). Each result beat passes through the output
// register, which holds it while the next step proceeds. Config writes are
// always accepted and take effect on the next cycle.
module bankers_resource_allocator (
  input logic clk,
  input logic rst_n,
  bra_in_if.sink    in_ch,
  bra_out_if.source out_ch,
  bra_cfg_if.sink   cfg_ch
);
  import bra_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  amt_vec_t in_amt;
  logic [FIELD_W-1:0] fld [FIELD_CNT];

  assign fld[0] = in_ch.amount_0;
  assign fld[1] = in_ch.amount_1;
  assign fld[2] = in_ch.amount_2;
  assign fld[3] = in_ch.amount_3;
  assign fld[4] = in_ch.amount_4;

  always_comb begin
    for (int k = 0; k < NUM_RES; k++) begin
      in_amt[k] = (k < FIELD_CNT) ? AMOUNT_WIDTH'(fld[k % FIELD_CNT]) : '0;
    end
  end

  assign cfg_ch.ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_subject (out_ch.subject_id),
    .out_last    (out_ch.last),
    .cmd         (dp_cmd),
    .stat        (dp_stat)
  );

  bra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_opcode (in_ch.opcode),
    .in_pid    (in_ch.process_id),
    .in_amt    (in_amt),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.q_cnt <= QC_W'(QUEUE_DEPTH))
    else $error("wait queue count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while busy");

  a_latch_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == DP_LATCH) |-> (in_ch.valid && in_ch.ready))
    else $error("request latched without an input beat");

endmodule
